@@ rtl/dkdt_pkg.sv @@
// ----------------------------------------------------------------------------
// dkdt_pkg
// Shared types and constants for the dual key device table.
// ----------------------------------------------------------------------------
package dkdt_pkg;

  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_KEY_BYTES = 8;

  localparam int OP_W     = 3;
  localparam int ID_W     = 32;
  localparam int HANDLE_W = 16;
  localparam int SECRET_W = 64;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_ID  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_H   = 3'd2;
  localparam logic [OP_W-1:0] OP_CHK_KEY = 3'd3;
  localparam logic [OP_W-1:0] OP_ID_OF_H = 3'd4;
  localparam logic [OP_W-1:0] OP_H_OF_ID = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CMP    = 5'b00010,
    S_SEL    = 5'b00100,
    S_COMMIT = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic sel;
    logic commit;
  } dp_cmd_t;

endpackage

@@ rtl/dkdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// dkdt_ctrl
// Request sequencer: load, compare, select, commit, then hold the result word.
// ----------------------------------------------------------------------------
module dkdt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output dkdt_pkg::dp_cmd_t cmd
);
  import dkdt_pkg::*;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CMP;
      S_CMP:    state_next = S_SEL;
      S_SEL:    state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.cmp    = (state == S_CMP);
  assign cmd.sel    = (state == S_SEL);
  assign cmd.commit = (state == S_COMMIT);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_commit_out: assert property (@(posedge clk) disable iff (rst) cmd.commit |=> out_valid)
    else $error("commit not followed by result");
  a_load_cmp: assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.cmp)
    else $error("load not followed by compare");

endmodule

@@ rtl/dkdt_datapath.sv @@
// ----------------------------------------------------------------------------
// dkdt_datapath
// Entry cells, parallel match, first-match select and table update.
// ----------------------------------------------------------------------------
module dkdt_datapath #(
  parameter int ENTRIES   = dkdt_pkg::DEF_ENTRIES,
  parameter int KEY_BYTES = dkdt_pkg::DEF_KEY_BYTES,
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dkdt_pkg::dp_cmd_t                     cmd,
  input  logic [dkdt_pkg::OP_W-1:0]             op,
  input  logic signed [dkdt_pkg::ID_W-1:0]      dev_id,
  input  logic [dkdt_pkg::HANDLE_W-1:0]         conn_handle,
  input  logic [dkdt_pkg::SECRET_W-1:0]         secret,
  output logic                                  ok,
  output logic signed [dkdt_pkg::ID_W-1:0]      found_id,
  output logic signed [dkdt_pkg::HANDLE_W:0]    found_handle,
  output logic [CW-1:0]                         entry_count
);
  import dkdt_pkg::*;

  localparam int KW = 8 * KEY_BYTES;

  logic [OP_W-1:0]     r_op;
  logic [ID_W-1:0]     r_id;
  logic [HANDLE_W-1:0] r_h;
  logic [KW-1:0]       r_key;

  logic [ENTRIES-1:0]  valid;
  logic [ID_W-1:0]     s_id  [ENTRIES];
  logic [HANDLE_W-1:0] s_h   [ENTRIES];
  logic [KW-1:0]       s_key [ENTRIES];
  logic [CW-1:0]       count;

  logic [ENTRIES-1:0]  mvec;
  logic [ENTRIES-1:0]  ge_mask;
  logic [ENTRIES-1:0]  first_oh;
  logic                id_any;
  logic                hit;

  logic [ENTRIES-1:0]  hit_id;
  logic [ENTRIES-1:0]  hit_h;
  logic [ENTRIES-1:0]  hit_key;
  logic [ENTRIES-1:0]  mvec_next;
  logic [ID_W-1:0]     sel_id;
  logic [HANDLE_W-1:0] sel_h;
  logic                ins_ok;
  logic                del_ok;
  logic                look_ok;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_id[i]  = valid[i] && (s_id[i] == r_id);
      hit_h[i]   = valid[i] && (s_h[i] == r_h);
      hit_key[i] = hit_id[i] && (s_key[i] == r_key);
    end
    unique case (r_op)
      OP_DEL_H, OP_ID_OF_H: mvec_next = hit_h;
      OP_CHK_KEY:           mvec_next = hit_key;
      default:              mvec_next = hit_id;
    endcase
  end

  always_comb begin
    sel_id = '0;
    sel_h  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_id = sel_id | ({ID_W{first_oh[i]}} & s_id[i]);
      sel_h  = sel_h  | ({HANDLE_W{first_oh[i]}} & s_h[i]);
    end
  end

  assign ins_ok  = (r_op == OP_INSERT) && !id_any && (count < CW'(ENTRIES));
  assign del_ok  = ((r_op == OP_DEL_ID) || (r_op == OP_DEL_H)) && hit;
  assign look_ok = ((r_op == OP_CHK_KEY) || (r_op == OP_ID_OF_H) ||
                    (r_op == OP_H_OF_ID)) && hit;

  // request and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op  <= op;
      r_id  <= dev_id;
      r_h   <= conn_handle;
      r_key <= secret[KW-1:0];
    end
    if (cmd.cmp) begin
      mvec   <= mvec_next;
      id_any <= |hit_id;
    end
    if (cmd.sel) begin
      ge_mask  <= ~mvec + ENTRIES'(1);
      first_oh <= mvec & (~mvec + ENTRIES'(1));
      hit      <= |mvec;
    end
  end

  // entry cells, newest in cell 0
  always_ff @(posedge clk) begin
    if (cmd.commit && ins_ok) begin
      for (int i = ENTRIES - 1; i > 0; i--) begin
        s_id[i]  <= s_id[i-1];
        s_h[i]   <= s_h[i-1];
        s_key[i] <= s_key[i-1];
      end
      s_id[0]  <= r_id;
      s_h[0]   <= r_h;
      s_key[0] <= r_key;
    end else if (cmd.commit && del_ok) begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (ge_mask[i]) begin
          s_id[i]  <= s_id[i+1];
          s_h[i]   <= s_h[i+1];
          s_key[i] <= s_key[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit && ins_ok) begin
      valid <= {valid[ENTRIES-2:0], 1'b1};
      count <= count + CW'(1);
    end else if (cmd.commit && del_ok) begin
      valid <= valid >> 1;
      count <= count - CW'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok           <= ins_ok || del_ok || look_ok;
      found_id     <= ((r_op == OP_ID_OF_H) && hit) ? sel_id : '1;
      found_handle <= ((r_op == OP_H_OF_ID) && hit) ? {1'b0, sel_h} : '1;
      if (ins_ok) begin
        entry_count <= count + CW'(1);
      end else if (del_ok) begin
        entry_count <= count - CW'(1);
      end else begin
        entry_count <= count;
      end
    end
  end

  a_first_sub: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.sel) |-> ((first_oh & ~mvec) == '0))
    else $error("selected entry not a match");
  a_first_one: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.sel) |-> $onehot0(first_oh))
    else $error("more than one entry selected");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("count overflow");

endmodule

@@ rtl/dual_key_device_table.sv @@
// ----------------------------------------------------------------------------
// dual_key_device_table
// Bounded newest-first device table keyed by id and by connection handle.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid in_ready op dev_id conn_handle   | in
//          | secret                                    |
//  result  | out_valid out_ready ok found_id           | out
//          | found_handle entry_count                  |
//
//  A request word passes through compare, select and commit before its result
//  word is offered: compare all cells, pick the first match, update the cells.
//  The next request is taken in the cycle after the result word is taken.
//  Reset empties the table; a stalled result holds its word.
// ----------------------------------------------------------------------------
module dual_key_device_table #(
  parameter int ENTRIES   = dkdt_pkg::DEF_ENTRIES,
  parameter int KEY_BYTES = dkdt_pkg::DEF_KEY_BYTES,
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dkdt_pkg::OP_W-1:0]          op,
  input  logic signed [dkdt_pkg::ID_W-1:0]   dev_id,
  input  logic [dkdt_pkg::HANDLE_W-1:0]      conn_handle,
  input  logic [dkdt_pkg::SECRET_W-1:0]      secret,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               ok,
  output logic signed [dkdt_pkg::ID_W-1:0]   found_id,
  output logic signed [dkdt_pkg::HANDLE_W:0] found_handle,
  output logic [CW-1:0]                      entry_count
);
  import dkdt_pkg::*;

  dp_cmd_t cmd;

  dkdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dkdt_datapath #(
    .ENTRIES   (ENTRIES),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .op           (op),
    .dev_id       (dev_id),
    .conn_handle  (conn_handle),
    .secret       (secret),
    .ok           (ok),
    .found_id     (found_id),
    .found_handle (found_handle),
    .entry_count  (entry_count)
  );

endmodule
